// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL. Each macro takes a label, a trigger
// and a consequence, and samples on clk with rst_n as the disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ZTD_ASSERT_IMP(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

`define ZTD_ASSERT_NXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ZTD_ASSERT_IMP(lbl, trig, cons)

`define ZTD_ASSERT_NXT(lbl, trig, cons)

`endif

`endif

// ===== rtl/ztd_pkg.sv =====
package ztd_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_TEST,
    ST_DONE
  } ztd_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic trial_start;
    logic div_step;
    logic next_trial;
    logic out_load;
    logic out_bit;
  } ztd_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic m_small;
    logic m_even;
    logic bound_over;
    logic div_last;
    logic rem_zero;
    logic out_free;
  } ztd_sts_t;

endpackage

// ===== rtl/ztd_if.sv =====
interface ztd_in_if #(parameter int VALUE_WIDTH = 32);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] n_value;

  modport source (output valid, output n_value, input ready);
  modport sink   (input valid, input n_value, output ready);
endinterface

interface ztd_out_if;
  logic valid;
  logic ready;
  logic two_found;

  modport source (output valid, output two_found, input ready);
  modport sink   (input valid, input two_found, output ready);
endinterface

// ===== rtl/ztd_ctrl.sv =====
module ztd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ztd_pkg::ztd_sts_t sts,
  output ztd_pkg::ztd_cmd_t cmd
);
  import ztd_pkg::*;

  ztd_state_t state_r, state_nxt;
  logic       found_r, found_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      found_r <= found_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    found_nxt = found_r;
    cmd       = '0;
    cmd.out_bit = found_r;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // Small and even successors are settled without a trial.
        if (sts.m_small) begin
          found_nxt = 1'b0;
          state_nxt = ST_DONE;
        end else if (sts.m_even) begin
          found_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else if (sts.bound_over) begin
          found_nxt = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          cmd.trial_start = 1'b1;
          state_nxt       = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (sts.rem_zero) begin
          found_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          cmd.next_trial = 1'b1;
          state_nxt      = ST_CHECK;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/ztd_dp.sv =====
module ztd_dp #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [VALUE_WIDTH-1:0] n_value,
  input  logic                   out_ready,
  input  ztd_pkg::ztd_cmd_t      cmd,
  output ztd_pkg::ztd_sts_t      sts,
  output logic                   out_valid,
  output logic                   out_bit
);
  import ztd_pkg::*;

  // The successor needs one more bit than n; trial divisors never pass
  // its square root, so about half that width holds them.
  localparam int MW = VALUE_WIDTH + 1;
  localparam int DW = (MW + 1) / 2 + 1;
  localparam int SW = 2 * DW;
  localparam int CW = $clog2(MW);

  logic [MW-1:0] m_r, m_nxt;
  logic [MW-1:0] sh_r, sh_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [SW-1:0] sq_r, sq_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_bit_r, out_bit_nxt;
  logic [DW:0]   rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r       <= m_nxt;
    sh_r      <= sh_nxt;
    d_r       <= d_nxt;
    sq_r      <= sq_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    out_bit_r <= out_bit_nxt;
  end

  assign rem_sh = {rem_r, sh_r[MW-1]};

  always_comb begin
    m_nxt   = m_r;
    sh_nxt  = sh_r;
    d_nxt   = d_r;
    sq_nxt  = sq_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      m_nxt  = MW'(n_value) + MW'(1);
      d_nxt  = DW'(3);
      sq_nxt = SW'(9);
    end
    if (cmd.trial_start) begin
      sh_nxt  = m_r;
      rem_nxt = '0;
      cnt_nxt = CW'(MW - 1);
    end
    // One restoring step: bring in the next bit of m, subtract if it fits.
    if (cmd.div_step) begin
      sh_nxt  = {sh_r[MW-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (rem_sh >= {1'b0, d_r}) begin
        rem_nxt = DW'(rem_sh - {1'b0, d_r});
      end else begin
        rem_nxt = DW'(rem_sh);
      end
    end
    // (d+2)^2 = d^2 + 4d + 4 keeps the bound check free of a multiplier.
    if (cmd.next_trial) begin
      d_nxt  = d_r + DW'(2);
      sq_nxt = sq_r + SW'({d_r, 2'b00}) + SW'(4);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_bit_nxt   = out_bit_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_bit_nxt   = cmd.out_bit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    sts.m_small    = (m_r < MW'(4));
    sts.m_even     = ~m_r[0];
    sts.bound_over = (sq_r > SW'(m_r));
    sts.div_last   = (cnt_r == '0);
    sts.rem_zero   = (rem_r == '0);
    sts.out_free   = ~out_valid_r | out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_bit   = out_bit_r;

endmodule

// ===== rtl/zone_two_trial_divisor_search.sv =====
// Successor compositeness check. Each beat on in_ch carries n_value; the
// block answers with one beat on out_ch whose two_found is set when n+1 is
// composite and clear when n+1 is prime or below 4.
// Both channels use valid/ready; a beat moves when both are high.
// The accept cycle loads n+1 and a bound check follows; small and even
// successors then go to the done state, which writes the result register
// behind out_ch.valid. Odd ones run the odd trial divisors from 3 up while
// d*d <= n+1; each trial is a bound check, a radix-2 restoring remainder
// over the VALUE_WIDTH+1 bits of n+1 and a zero test. The search stops at
// the first divisor found. The sequential remainder unit sets the run
// time; at worst, for a prime n+1, about sqrt(n+1)/2 trials are run.
// One item is in flight at a time: in_ch.ready is high only while idle.
// The result sits in an output register, so a new item is accepted while
// the previous result still waits; a stalled receiver holds the block only
// when the next result is ready and the register is still full.
// A synchronous active-low reset returns the block to idle and drops
// out_ch.valid; no item survives it.
module zone_two_trial_divisor_search #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  ztd_in_if.sink    in_ch,
  ztd_out_if.source out_ch
);
  import ztd_pkg::*;

  ztd_cmd_t cmd;
  ztd_sts_t sts;
  logic     in_ready;

  ztd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ztd_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .n_value   (in_ch.n_value),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_ch.valid),
    .out_bit   (out_ch.two_found)
  );

  assign in_ch.ready = in_ready;

`include "assert_macros.svh"

  `ZTD_ASSERT_NXT(a_busy_after_load, cmd.load, !in_ready)
  `ZTD_ASSERT_IMP(a_no_result_overwrite, cmd.out_load, sts.out_free)
  `ZTD_ASSERT_IMP(a_trial_odd_only, cmd.trial_start, !sts.m_small && !sts.m_even)

endmodule

// ===== sim/zone_two_trial_divisor_search_test.sv =====
module zone_two_trial_divisor_search_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_WIDTH = 32;
  localparam int RANDOM_ITEMS = 1450;
  localparam int BLOCK_ITEMS = 50;
  localparam int DRAIN_CYCLES = 2 * (VALUE_WIDTH + 3) + 10;
  // The slowest search in the stimulus is the prime just below 2^24, at about
  // 2048 trials; everything else is far shorter. This is more than twice the
  // worst case of all mid-range values being primes.
  localparam longint CYCLE_LIMIT = 15_000_000;

  typedef logic [VALUE_WIDTH-1:0] value_t;

  typedef struct {
    value_t n;
    logic   composite;
  } verdict_t;

  class successor_board;
    verdict_t verdict_q[$];
    int       mismatches;

    function logic successor_composite(value_t n);
      longint unsigned m;
      longint unsigned d;
      m = 64'(n) + 64'd1;
      if (m < 64'd4) return 1'b0;
      if (m[0] == 1'b0) return 1'b1;
      for (d = 64'd3; d <= m / d; d += 64'd2) begin
        if (m % d == 64'd0) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_value(value_t n);
      verdict_t v;
      v.n = n;
      v.composite = successor_composite(n);
      verdict_q.push_back(v);
    endfunction

    function void check_flag(logic got);
      verdict_t v;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result beat: two_found=%b", got);
        end
        return;
      end
      v = verdict_q.pop_front();
      if (got !== v.composite) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("n=%0d: two_found expected %b, got %b", v.n, v.composite, got);
        end
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic   clk;
  logic   rst_n;
  longint cycles = 0;
  bit     quiet_phase;

  successor_board board;

  ztd_in_if #(.VALUE_WIDTH(VALUE_WIDTH)) in_ch();
  ztd_out_if out_ch();

  zone_two_trial_divisor_search #(.VALUE_WIDTH(VALUE_WIDTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("zone_two_trial_divisor_search_test: errors");
      $finish;
    end
  end

  // Valid stays high across back-to-back beats; it is lowered only when a gap
  // follows, so it never gets two assignments in one step.
  task automatic send_value(input value_t n);
    int gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.n_value <= n;
    do @(posedge clk); while (!in_ch.ready);
    board.note_value(n);
  endtask

  task automatic drain_results();
    int stall;
    forever begin
      stall = quiet_phase ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      board.check_flag(out_ch.two_found);
    end
  endtask

  // Large values are pulled down so that n+1 has a factor of at most 13,
  // which keeps the search to a handful of trials while all bits vary.
  function automatic value_t pick_large();
    longint unsigned m;
    longint unsigned k;
    int unsigned     sel;
    sel = $urandom_range(0, 5);
    case (sel)
      0: k = 2;
      1: k = 3;
      2: k = 5;
      3: k = 7;
      4: k = 11;
      default: k = 13;
    endcase
    m = 64'(value_t'($urandom())) + 64'd1;
    m = m - (m % k);
    if (m == 64'd0) m = 2 * k;
    return value_t'(m - 64'd1);
  endfunction

  function automatic value_t pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return value_t'($urandom_range(0, 4095));
    if (roll < 80) return value_t'($urandom_range(0, 65535));
    return pick_large();
  endfunction

  value_t directed_values[] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd8, 32'd24, 32'd48,
    32'd120, 32'd63000, 32'd65520, 32'd1000000, 32'd1048572, 32'd16777212,
    32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h5555_5554, 32'h8000_0000, 32'h7FFF_FFFF,
    32'hAAAA_AAA9, 32'h0000_FFFE
  };

  initial begin
    int errors;
    board = new();
    quiet_phase = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.n_value <= '0;
    out_ch.ready <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    fork
      drain_results();
    join_none

    foreach (directed_values[i]) begin
      send_value(directed_values[i]);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % BLOCK_ITEMS == 0) begin
        quiet_phase = ($urandom_range(0, 3) == 0);
      end
      send_value(pick_value());
    end
    @(posedge clk);
    in_ch.valid <= 1'b0;
    quiet_phase = 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    errors = board.mismatches + board.pending();
    if (errors == 0) begin
      $display("zone_two_trial_divisor_search_test: clean");
    end else begin
      $display("zone_two_trial_divisor_search_test: errors");
    end
    $finish;
  end

endmodule
